>>> rtl/core/pgmsd_pkg.sv
// pgmsd_pkg: shared types and codes for the pgm stream decoder
// holds the header phase and magic enums, result codes and the queue record types
// no dependencies
package pgmsd_pkg;

    // header parsing phase
    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_DRAIN
    } phase_t;

    // progress of the magic token match
    typedef enum logic [2:0] {
        MM_EMPTY,
        MM_P,
        MM_P5,
        MM_P2,
        MM_NONE
    } magic_t;

    // result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_SHORT_BIN = 3'd3;
    localparam logic [2:0] ST_PADDED    = 3'd4;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pixel_value;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // queue entry: the results of one input byte, one or two of them
    typedef struct packed {
        logic    two;
        result_t r_first;
        result_t r_second;
    } pair_t;

    // queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/core/pgmsd_front.sv
// pgmsd_front: byte parser, one input byte per cycle while accept is high
// tokenizes the header, tracks pixel position and builds the results of each byte
// depends on pgmsd_pkg
module pgmsd_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        data_byte,
    input  logic              end_of_file,
    input  logic              accept,
    output logic              push,
    output pgmsd_pkg::pair_t  push_data
);
    import pgmsd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    phase_t             phase_reg, phase_next;
    logic               comment_reg, comment_next;
    logic               tok_reg, tok_next;
    logic               num_reg, num_next;
    logic [30:0]        val_reg, val_next;
    magic_t             mm_reg, mm_next;
    logic               binary_reg, binary_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;

    // decode signals
    logic               ws, is_digit, text_path, add_byte, end_ws, do_end;
    logic [34:0]        prod;
    logic               a_num, u_num;
    logic [30:0]        u_val, v;
    magic_t             a_mm, u_mm;
    logic               magic_ok, size_ok, dim_ok;
    logic               pix_go, wrap, img_done;
    logic [7:0]         pix_val;
    logic [DIM_W-1:0]   col_inc, row_inc;
    phase_t             phase_mid;
    logic               tail_go;
    logic [1:0]         tail_kind;
    logic [2:0]         tail_status;
    logic [DIM_W-1:0]   width_upd, height_upd;
    result_t            pix_rec, tail_rec;

    // byte classification, token update and event decode
    always_comb begin
        ws        = data_byte inside {CH_SP, CH_TAB, CH_LF, CH_CR};
        is_digit  = data_byte inside {[CH_0:CH_9]};
        text_path = (phase_reg != PH_DRAIN) && !((phase_reg == PH_PIXELS) && binary_reg);
        add_byte  = text_path && !comment_reg && !ws && (tok_reg || (data_byte != CH_HASH));
        end_ws    = text_path && !comment_reg && tok_reg && ws;
        do_end    = end_ws || (add_byte && end_of_file);

        // value times ten plus digit, overflow past 31 bits kills the token
        prod  = {1'b0, val_reg, 3'b000} + {3'b000, val_reg, 1'b0} + {31'd0, data_byte[3:0]};
        a_num = num_reg && is_digit && (prod[34:31] == 4'd0);

        case (mm_reg)
            MM_EMPTY: a_mm = (data_byte == CH_P) ? MM_P : MM_NONE;
            MM_P: begin
                if (data_byte == CH_5) begin
                    a_mm = MM_P5;
                end else if (data_byte == CH_2) begin
                    a_mm = MM_P2;
                end else begin
                    a_mm = MM_NONE;
                end
            end
            default: a_mm = MM_NONE;
        endcase

        // token that ends: as held, or with this byte when the file ends on it
        u_num = end_ws ? num_reg : a_num;
        u_val = end_ws ? val_reg : prod[30:0];
        u_mm  = end_ws ? mm_reg : a_mm;
        v     = u_num ? u_val : 31'd0;

        magic_ok = (u_mm == MM_P5) || (u_mm == MM_P2);
        dim_ok   = (v != 31'd0) && ({1'b0, v} <= 32'(MAX_DIM));
        size_ok  = (width_reg != '0) && (height_reg != '0) && (v != 31'd0);

        // pixel position step
        pix_go   = (phase_reg == PH_PIXELS) && (binary_reg || do_end);
        pix_val  = binary_reg ? data_byte : v[7:0];
        col_inc  = col_reg + DIM_W'(1);
        wrap     = col_inc >= width_reg;
        row_inc  = row_reg + DIM_W'(wrap);
        img_done = row_inc >= height_reg;

        // phase once the ending token is handled
        phase_mid = phase_reg;
        if (do_end) begin
            case (phase_reg)
                PH_MAGIC:  phase_mid = magic_ok ? PH_WIDTH : PH_MAGIC;
                PH_WIDTH:  phase_mid = PH_HEIGHT;
                PH_HEIGHT: phase_mid = PH_MAXVAL;
                PH_MAXVAL: phase_mid = size_ok ? PH_PIXELS : PH_MAXVAL;
                default:   phase_mid = phase_reg;
            endcase
        end

        // closing result: finish, error or padded finish
        tail_go     = 1'b0;
        tail_kind   = KIND_DONE;
        tail_status = ST_OK;
        if (pix_go && img_done) begin
            tail_go = 1'b1;
        end else if (do_end && (phase_reg == PH_MAGIC) && !magic_ok) begin
            tail_go     = 1'b1;
            tail_kind   = KIND_ERROR;
            tail_status = ST_BAD_MAGIC;
        end else if (do_end && (phase_reg == PH_MAXVAL) && !size_ok) begin
            tail_go     = 1'b1;
            tail_kind   = KIND_ERROR;
            tail_status = ST_BAD_SIZE;
        end else if (end_of_file && (phase_reg != PH_DRAIN)) begin
            case (phase_mid)
                PH_MAGIC: begin
                    tail_go     = 1'b1;
                    tail_kind   = KIND_ERROR;
                    tail_status = ST_BAD_MAGIC;
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                    tail_go     = 1'b1;
                    tail_kind   = KIND_ERROR;
                    tail_status = ST_BAD_SIZE;
                end
                PH_PIXELS: begin
                    tail_go     = 1'b1;
                    tail_kind   = binary_reg ? KIND_ERROR : KIND_DONE;
                    tail_status = binary_reg ? ST_SHORT_BIN : ST_PADDED;
                end
                default: tail_go = 1'b0;
            endcase
        end

        // size registers as seen by this byte's results
        width_upd  = width_reg;
        height_upd = height_reg;
        if (do_end && (phase_reg == PH_WIDTH)) begin
            width_upd = dim_ok ? DIM_W'(v) : '0;
        end
        if (do_end && (phase_reg == PH_HEIGHT)) begin
            height_upd = dim_ok ? DIM_W'(v) : '0;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (end_of_file) begin
                phase_next = PH_MAGIC;
            end else if (tail_go) begin
                phase_next = PH_DRAIN;
            end else begin
                phase_next = phase_mid;
            end
        end
    end

    // results and datapath register updates
    always_comb begin
        pix_rec              = '0;
        pix_rec.kind         = KIND_PIXEL;
        pix_rec.pixel_value  = pix_val;
        pix_rec.column       = 12'(col_reg);
        pix_rec.row          = 12'(row_reg);
        pix_rec.image_width  = 13'(width_upd);
        pix_rec.image_height = 13'(height_upd);
        pix_rec.status       = ST_OK;

        tail_rec              = '0;
        tail_rec.kind         = tail_kind;
        tail_rec.image_width  = 13'(width_upd);
        tail_rec.image_height = 13'(height_upd);
        tail_rec.status       = tail_status;
        tail_rec.last         = 1'b1;

        push               = accept && (pix_go || tail_go);
        push_data.two      = pix_go && tail_go;
        push_data.r_first  = pix_go ? pix_rec : tail_rec;
        push_data.r_second = tail_rec;

        comment_next = comment_reg;
        tok_next     = tok_reg;
        num_next     = num_reg;
        val_next     = val_reg;
        mm_next      = mm_reg;
        binary_next  = binary_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        col_next     = col_reg;
        row_next     = row_reg;

        if (accept) begin
            // comment tracking
            if (text_path) begin
                if (comment_reg) begin
                    comment_next = data_byte != CH_LF;
                end else if (!tok_reg && (data_byte == CH_HASH)) begin
                    comment_next = 1'b1;
                end
            end
            // token accumulate or clear
            if (do_end) begin
                tok_next = 1'b0;
                num_next = 1'b1;
                val_next = '0;
                mm_next  = MM_EMPTY;
            end else if (add_byte) begin
                tok_next = 1'b1;
                num_next = a_num;
                val_next = prod[30:0];
                mm_next  = a_mm;
            end
            if (do_end && (phase_reg == PH_MAGIC) && magic_ok) begin
                binary_next = u_mm == MM_P5;
            end
            width_next  = width_upd;
            height_next = height_upd;
            if (pix_go) begin
                col_next = wrap ? '0 : col_inc;
                row_next = row_inc;
            end
            // end of file returns everything to the start of a new file
            if (end_of_file) begin
                comment_next = 1'b0;
                tok_next     = 1'b0;
                num_next     = 1'b1;
                val_next     = '0;
                mm_next      = MM_EMPTY;
                binary_next  = 1'b0;
                width_next   = '0;
                height_next  = '0;
                col_next     = '0;
                row_next     = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAGIC;
            comment_reg <= 1'b0;
            tok_reg     <= 1'b0;
            num_reg     <= 1'b1;
            val_reg     <= '0;
            mm_reg      <= MM_EMPTY;
            binary_reg  <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            tok_reg     <= tok_next;
            num_reg     <= num_next;
            val_reg     <= val_next;
            mm_reg      <= mm_next;
            binary_reg  <= binary_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

>>> rtl/core/pgmsd_queue.sv
// pgmsd_queue: small queue of per-byte result entries between parser and output side
// circular register array with read and write pointers and a fill count
// depends on pgmsd_pkg
module pgmsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pgmsd_pkg::pair_t    push_data,
    input  logic                pop,
    output pgmsd_pkg::pair_t    head,
    output pgmsd_pkg::q_stat_t  stat
);
    import pgmsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pair_t            entry_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // status and head entry
    assign stat.full  = count_reg == CW'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign head       = entry_reg[rptr_reg];

    // pointer and count update
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/pgmsd_back.sv
// pgmsd_back: output side, splits queue entries into single results
// drives the registered result channel, one transfer per cycle while out_ready is high
// depends on pgmsd_pkg
module pgmsd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  pgmsd_pkg::pair_t    head,
    input  pgmsd_pkg::q_stat_t  stat,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output pgmsd_pkg::result_t  out_data
);
    import pgmsd_pkg::*;

    logic     valid_reg, valid_next;
    logic     sel_reg, sel_next;
    result_t  data_reg, data_next;
    logic     load, take;

    // load the output register when it is empty or being taken
    always_comb begin
        load       = !valid_reg || out_ready;
        take       = load && !stat.empty;
        pop        = take && (sel_reg || !head.two);
        valid_next = valid_reg;
        sel_next   = sel_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = take;
        end
        if (take) begin
            data_next = sel_reg ? head.r_second : head.r_first;
            sel_next  = head.two && !sel_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/pgm_stream_decoder_unit.sv
// pgm_stream_decoder_unit: top level of the streaming PGM (P2/P5) decoder
// channel   dir  ports                                             transfer
// s_        in   s_data_byte, s_end_of_file                        s_valid & s_ready
// m_        out  m_kind, m_pixel_value, m_column, m_row,           m_valid & m_ready
//                m_image_width, m_image_height, m_status, m_last
// one byte is taken per cycle while s_ready is high; a result passes through the queue
// and then the output register before it leaves
// the output side moves one result per cycle while m_ready is high; a byte that ends
// the image with a pixel gives two results in two transfers, the queue absorbs this
// s_ready drops only when the result queue (QUEUE_DEPTH entries) is full
// synchronous active-low reset, no clearing pass; a new file may start right after reset
// depends on pgmsd_pkg, pgmsd_front, pgmsd_queue, pgmsd_back
module pgm_stream_decoder_unit #(
    parameter int MAX_DIM     = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    input  logic         s_end_of_file,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_kind,
    output logic [7:0]   m_pixel_value,
    output logic [11:0]  m_column,
    output logic [11:0]  m_row,
    output logic [12:0]  m_image_width,
    output logic [12:0]  m_image_height,
    output logic [2:0]   m_status,
    output logic         m_last
);
    import pgmsd_pkg::*;

    logic     accept, push, pop;
    pair_t    push_data, head;
    q_stat_t  q_stat;
    result_t  out_data;

    // input transfer when the queue has room
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // parser
    pgmsd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_data_byte),
        .end_of_file (s_end_of_file),
        .accept      (accept),
        .push        (push),
        .push_data   (push_data)
    );

    // result queue
    pgmsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // output side
    pgmsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .stat      (q_stat),
        .pop       (pop),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data)
    );

    assign m_kind         = out_data.kind;
    assign m_pixel_value  = out_data.pixel_value;
    assign m_column       = out_data.column;
    assign m_row          = out_data.row;
    assign m_image_width  = out_data.image_width;
    assign m_image_height = out_data.image_height;
    assign m_status       = out_data.status;
    assign m_last         = out_data.last;

    // the parser writes the queue only on an input transfer
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_valid && s_ready))
        else $error("queue written without an input transfer");

    // the output side never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // pixels never close a file, every other result does
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind != KIND_PIXEL)))
        else $error("last flag does not match result kind");

    // a pixel result carries ok status
    a_pixel_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_PIXEL)) |-> (m_status == ST_OK))
        else $error("pixel result with nonzero status");

endmodule
